// ===== hdl/ets_pkg.sv =====
// ----------------------------------------------------------------------------
// ets_pkg
// Shared types, token kind codes, character codes and the character
// classifier for the expression token scanner.
// ----------------------------------------------------------------------------
package ets_pkg;

  localparam int POS_WIDTH_DEF = 16;
  localparam int CQ_DEPTH      = 4;
  localparam int OQ_DEPTH      = 4;

  // Token kinds
  localparam logic [3:0] KIND_PLUS     = 4'd0;
  localparam logic [3:0] KIND_MINUS    = 4'd1;
  localparam logic [3:0] KIND_MULTIPLY = 4'd2;
  localparam logic [3:0] KIND_DIVIDE   = 4'd3;
  localparam logic [3:0] KIND_EQUALS   = 4'd4;
  localparam logic [3:0] KIND_PAREN_O  = 4'd5;
  localparam logic [3:0] KIND_PAREN_C  = 4'd6;
  localparam logic [3:0] KIND_BRACK_O  = 4'd7;
  localparam logic [3:0] KIND_BRACK_C  = 4'd8;
  localparam logic [3:0] KIND_BRACE_O  = 4'd9;
  localparam logic [3:0] KIND_BRACE_C  = 4'd10;
  localparam logic [3:0] KIND_NUMBER   = 4'd11;
  localparam logic [3:0] KIND_VARIABLE = 4'd12;
  localparam logic [3:0] KIND_ERROR    = 4'd13;

  // ASCII codes
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_PAREN_O = 8'h28;
  localparam logic [7:0] CH_PAREN_C = 8'h29;
  localparam logic [7:0] CH_BRACK_O = 8'h5B;
  localparam logic [7:0] CH_BRACK_C = 8'h5D;
  localparam logic [7:0] CH_BRACE_O = 8'h7B;
  localparam logic [7:0] CH_BRACE_C = 8'h7D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_VAR
  } mode_t;

  typedef enum logic [2:0] {
    CLS_BLANK,
    CLS_OP,
    CLS_DIGIT,
    CLS_LETTER,
    CLS_UNDER,
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       final_char;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] begin_pos;
    logic [16:0] end_pos;
    logic        last_of_run;
  } out_item_t;

  // Classified character handed from front to back
  typedef struct packed {
    cls_t       cls;
    logic [3:0] op_kind;
    logic       fin;
  } cls_item_t;

  localparam int CLS_ITEM_W = $bits(cls_item_t);

  function automatic cls_item_t classify(logic [7:0] c, logic fin);
    cls_item_t r;
    r.fin     = fin;
    r.op_kind = KIND_ERROR;
    r.cls     = CLS_OP;
    case (c)
      CH_PLUS:    r.op_kind = KIND_PLUS;
      CH_MINUS:   r.op_kind = KIND_MINUS;
      CH_STAR:    r.op_kind = KIND_MULTIPLY;
      CH_COLON:   r.op_kind = KIND_DIVIDE;
      CH_SLASH:   r.op_kind = KIND_DIVIDE;
      CH_EQUALS:  r.op_kind = KIND_EQUALS;
      CH_PAREN_O: r.op_kind = KIND_PAREN_O;
      CH_PAREN_C: r.op_kind = KIND_PAREN_C;
      CH_BRACK_O: r.op_kind = KIND_BRACK_O;
      CH_BRACK_C: r.op_kind = KIND_BRACK_C;
      CH_BRACE_O: r.op_kind = KIND_BRACE_O;
      CH_BRACE_C: r.op_kind = KIND_BRACE_C;
      CH_UNDER:   r.cls = CLS_UNDER;
      default: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          r.cls = CLS_DIGIT;
        end else if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                     (c >= CH_LOWER_A && c <= CH_LOWER_Z)) begin
          r.cls = CLS_LETTER;
        end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          r.cls = CLS_BLANK;
        end else begin
          r.cls = CLS_OTHER;
        end
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/expression_token_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// expression_token_scanner_unit
// Scans ASCII source text one character per item and emits arithmetic
// expression tokens: operators, numbers, variables and error tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_data (ch, final_char) and raise in_push; the item
//   is taken on a clock edge with in_push high and in_full low. Set
//   final_char on the last character of a text to flush a pending number or
//   variable; offsets restart at zero for the next text.
//   Result queue: while out_empty is low, out_data holds the oldest token
//   (kind, begin and end offsets, last_of_run on the final token caused by a
//   character). Raise out_pop to take it.
//   Path: an accepted character is written to the character queue; the
//   back takes it once two result entries are free and writes its tokens.
//   One character is accepted every cycle while in_full is low; the result
//   side delivers one token per cycle while out_pop is high, and a
//   character can cause two, so the sustained rate is set by the single-read result queue.
//   When out_pop stays low, the scanner holds once fewer than two of the four
//   result entries are free; the four-entry character queue fills and
//   in_full rises.
//   Reset (rst_n low, synchronous) empties both queues, drops any pending
//   token and sets the position counter to zero.
// ----------------------------------------------------------------------------
module expression_token_scanner_unit #(
  parameter int POS_WIDTH = ets_pkg::POS_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  ets_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output ets_pkg::out_item_t out_data
);

  import ets_pkg::*;

  localparam int CQ_W = CLS_ITEM_W + POS_WIDTH + 1;

  // Front to character queue
  logic               cq_push, cq_full;
  cls_item_t          f_item;
  logic [POS_WIDTH:0] f_pos;

  // Character queue to back
  logic               cq_pop, cq_empty;
  logic [CQ_W-1:0]    cq_dout;
  cls_item_t          b_item;
  logic [POS_WIDTH:0] b_pos;

  assign in_full = cq_full;

  // Classify and stamp each accepted character
  ets_front #(
    .POS_WIDTH(POS_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .cq_full (cq_full),
    .cq_push (cq_push),
    .citem   (f_item),
    .cpos    (f_pos)
  );

  // Decouple front and back so each side can stall on its own
  ets_fifo #(
    .WIDTH(CQ_W),
    .DEPTH(CQ_DEPTH)
  ) u_cq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .full  (cq_full),
    .din   ({f_item, f_pos}),
    .pop   (cq_pop),
    .empty (cq_empty),
    .dout  (cq_dout)
  );

  assign b_item = cls_item_t'(cq_dout[CQ_W-1 -: CLS_ITEM_W]);
  assign b_pos  = cq_dout[POS_WIDTH:0];

  // Form tokens and queue the result items
  ets_back #(
    .POS_WIDTH(POS_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cq_empty  (cq_empty),
    .citem     (b_item),
    .cpos      (b_pos),
    .cq_pop    (cq_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/ets_fifo.sv =====
// ----------------------------------------------------------------------------
// ets_fifo
// Small register queue with one write and one read per cycle.
// ----------------------------------------------------------------------------
module ets_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] q_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== hdl/ets_front.sv =====
// ----------------------------------------------------------------------------
// ets_front
// Accepts characters, classifies them and stamps each with its offset.
// ----------------------------------------------------------------------------
module ets_front #(
  parameter int POS_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  ets_pkg::in_item_t in_data,
  input  logic              cq_full,
  output logic              cq_push,
  output ets_pkg::cls_item_t citem,
  output logic [POS_WIDTH:0] cpos
);

  import ets_pkg::*;

  localparam logic [POS_WIDTH:0] LIM = {1'b1, {POS_WIDTH{1'b0}}};

  logic [POS_WIDTH:0] pos_r, pos_nxt;

  assign cq_push = in_push && !cq_full;
  assign citem   = classify(in_data.ch, in_data.final_char);
  assign cpos    = pos_r;

  // Saturate at the limit; restart at zero after the last character of a text
  always_comb begin
    pos_nxt = pos_r;
    if (cq_push) begin
      if (in_data.final_char) begin
        pos_nxt = '0;
      end else if (pos_r < LIM) begin
        pos_nxt = pos_r + (POS_WIDTH + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== hdl/ets_back.sv =====
// ----------------------------------------------------------------------------
// ets_back
// Token state machine: closes, opens and flushes tokens, and queues up to
// two result items per character.
// ----------------------------------------------------------------------------
module ets_back #(
  parameter int POS_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cq_empty,
  input  ets_pkg::cls_item_t  citem,
  input  logic [POS_WIDTH:0]  cpos,
  output logic                cq_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output ets_pkg::out_item_t  out_data
);

  import ets_pkg::*;

  localparam logic [POS_WIDTH:0]   LIM    = {1'b1, {POS_WIDTH{1'b0}}};
  localparam logic [POS_WIDTH-1:0] LIM_M1 = {POS_WIDTH{1'b1}};
  localparam int PTR_W = $clog2(OQ_DEPTH);
  localparam int CNT_W = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [3:0]           kind;
    logic [POS_WIDTH-1:0] b;
    logic [POS_WIDTH:0]   e;
  } tok_t;

  function automatic out_item_t to_out(tok_t t, logic last);
    out_item_t   o;
    logic [63:0] b64;
    logic [63:0] e64;
    b64           = 64'(t.b);
    e64           = 64'(t.e);
    o.token_kind  = t.kind;
    o.begin_pos   = b64[15:0];
    o.end_pos     = e64[16:0];
    o.last_of_run = last;
    return o;
  endfunction

  mode_t                mode_r, mode_nxt, mode1;
  logic [POS_WIDTH-1:0] start_r, start_nxt, start1;
  logic                 ext, close, single, flush, p_top, room, pop_en, rd;
  logic [3:0]           single_kind;
  logic [POS_WIDTH:0]   pnext;
  logic [POS_WIDTH-1:0] pclamp;
  logic [1:0]           ntok, nwr;
  tok_t                 tok_a, tok_s, tok_f, t0, t1;
  out_item_t            o0, o1;

  out_item_t            q_r [OQ_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]     cnt_r;

  assign room   = (cnt_r <= CNT_W'(OQ_DEPTH - 2));
  assign pop_en = !cq_empty && room;
  assign cq_pop = pop_en;

  assign p_top  = (cpos == LIM);
  assign pnext  = p_top ? cpos : cpos + (POS_WIDTH + 1)'(1);
  assign pclamp = p_top ? LIM_M1 : cpos[POS_WIDTH-1:0];

  // Next state and token selection
  always_comb begin
    ext = ((mode_r == MODE_NUM) && (citem.cls == CLS_DIGIT)) ||
          ((mode_r == MODE_VAR) && ((citem.cls == CLS_DIGIT) ||
                                    (citem.cls == CLS_LETTER) ||
                                    (citem.cls == CLS_UNDER)));
    close  = !ext && (mode_r != MODE_IDLE);
    single = !ext && ((citem.cls == CLS_OP) || (citem.cls == CLS_UNDER) ||
                      (citem.cls == CLS_OTHER));
    single_kind = (citem.cls == CLS_OP) ? citem.op_kind : KIND_ERROR;

    mode1  = mode_r;
    start1 = start_r;
    if (!ext) begin
      case (citem.cls)
        CLS_DIGIT: begin
          mode1  = MODE_NUM;
          start1 = pclamp;
        end
        CLS_LETTER: begin
          mode1  = MODE_VAR;
          start1 = pclamp;
        end
        default: mode1 = MODE_IDLE;
      endcase
    end
    flush = citem.fin && (mode1 != MODE_IDLE);

    tok_a.kind = (mode_r == MODE_NUM) ? KIND_NUMBER : KIND_VARIABLE;
    tok_a.b    = start_r;
    tok_a.e    = cpos;
    tok_s.kind = single_kind;
    tok_s.b    = pclamp;
    tok_s.e    = pnext;
    tok_f.kind = (mode1 == MODE_NUM) ? KIND_NUMBER : KIND_VARIABLE;
    tok_f.b    = start1;
    tok_f.e    = pnext;

    ntok = 2'(close) + 2'(single) + 2'(flush);
    t0   = close ? tok_a : (single ? tok_s : tok_f);
    t1   = single ? tok_s : tok_f;
    o0   = to_out(t0, ntok == 2'd1);
    o1   = to_out(t1, 1'b1);

    mode_nxt  = mode_r;
    start_nxt = start_r;
    if (pop_en) begin
      mode_nxt  = citem.fin ? MODE_IDLE : mode1;
      start_nxt = citem.fin ? '0 : start1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      start_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
    end
  end

  // Result queue: up to two writes, one read per cycle
  assign nwr       = pop_en ? ntok : 2'd0;
  assign out_empty = (cnt_r == '0);
  assign rd        = out_pop && !out_empty;
  assign out_data  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(nwr);
      rd_ptr_r <= rd_ptr_r + PTR_W'(rd);
      cnt_r    <= cnt_r + CNT_W'(nwr) - CNT_W'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (nwr != 2'd0) begin
      q_r[wr_ptr_r] <= o0;
    end
    if (nwr == 2'd2) begin
      q_r[wr_ptr_r + PTR_W'(1)] <= o1;
    end
  end

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(OQ_DEPTH))
    else $error("result queue over depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop_en |-> (32'(cnt_r) + 32'(nwr) <= OQ_DEPTH))
    else $error("result queue write overruns free space");

  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_en && citem.fin) |=> (mode_r == MODE_IDLE && start_r == '0))
    else $error("scanner not idle after last character");

endmodule
